// ----- hdl/bounded_list_engine_assert.svh -----
// Assertion macros shared by the list engine RTL.
`ifndef BOUNDED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define BLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list engine assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define BLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list engine assertion failed");

`endif

// ----- hdl/ble_pkg.sv -----
// Shared types and constants of the bounded list engine.
package ble_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W = 5;
  localparam int OP_W = 3;
  localparam int STAT_W = 2;
  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_PUSH_HEAD = 3'd1,
    OP_REM_MATCH = 3'd2,
    OP_REM_HEAD  = 3'd3,
    OP_REM_TAIL  = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TAKE,
    S_SEARCH,
    S_SHIFT,
    S_RD_HEAD,
    S_RD_TAIL,
    S_FIN
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   removed_value;
    logic [DATA_W-1:0]   head_value;
    logic [DATA_W-1:0]   tail_value;
    logic [CNT_W-1:0]    count;
  } result_t;

endpackage

// ----- hdl/ble_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ble_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/ble_seq.sv -----
// Sequencer that reads, modifies and writes back the list ring in the RAM.
module ble_seq #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ble_pkg::CNT_W-1:0]   capacity,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ble_pkg::OP_W-1:0]    opcode,
  input  logic [ble_pkg::DATA_W-1:0]  value,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ble_pkg::result_t            res
);
  import ble_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int LIM_CAP = (MAX_ENTRIES > 31) ? 31 : MAX_ENTRIES;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

  state_t               state, state_next;
  op_t                  op;
  logic [DATA_W-1:0]    val;
  logic [IDX_W-1:0]     front;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     idx;
  status_t              stat;
  logic [DATA_W-1:0]    removed;
  logic [DATA_W-1:0]    head;

  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0]    ram_wdata, ram_rdata;

  logic [CNT_W-1:0]     limit;
  logic                 full, empty, match;
  logic [CNT_W:0]       idx1, idx2;
  logic                 more1, more2;
  logic [IDX_W-1:0]     front_inc, front_dec;

  // Ring position of the k-th entry, wrapped once; it is valid for k below the store depth.
  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(k);
    if (sum >= SUM_W'(MAX_ENTRIES)) begin
      sum = sum - SUM_W'(MAX_ENTRIES);
    end
    return sum[IDX_W-1:0];
  endfunction

  ble_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign limit = (capacity > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : capacity;
  assign full = (cnt >= limit);
  assign empty = (cnt == '0);
  assign match = (ram_rdata == val);
  assign idx1 = {1'b0, idx} + (CNT_W+1)'(1);
  assign idx2 = {1'b0, idx} + (CNT_W+1)'(2);
  assign more1 = (idx1 < {1'b0, cnt});
  assign more2 = (idx2 < {1'b0, cnt});
  assign front_inc = (front == LAST_IDX) ? '0 : front + IDX_W'(1);
  assign front_dec = (front == '0) ? LAST_IDX : front - IDX_W'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (op) inside
          OP_REM_MATCH: state_next = empty ? S_RD_HEAD : S_SEARCH;
          OP_REM_HEAD, OP_REM_TAIL: state_next = empty ? S_RD_HEAD : S_TAKE;
          default: state_next = S_RD_HEAD;
        endcase
      end
      S_TAKE: state_next = S_RD_HEAD;
      S_SEARCH: begin
        if (match) begin
          state_next = more1 ? S_SHIFT : S_RD_HEAD;
        end else if (!more1) begin
          state_next = S_RD_HEAD;
        end
      end
      S_SHIFT: begin
        if (!more2) state_next = S_RD_HEAD;
      end
      S_RD_HEAD: state_next = S_RD_TAIL;
      S_RD_TAIL: state_next = S_FIN;
      S_FIN: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    res_valid = 1'b0;
    ram_we = 1'b0;
    ram_waddr = front;
    ram_wdata = val;
    ram_re = 1'b0;
    ram_raddr = front;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_DECODE: begin
        case (op) inside
          OP_APPEND: begin
            ram_we = !full;
            ram_waddr = slot(front, cnt);
          end
          OP_PUSH_HEAD: begin
            ram_we = !full;
            ram_waddr = front_dec;
          end
          OP_REM_MATCH, OP_REM_HEAD: ram_re = !empty;
          OP_REM_TAIL: begin
            ram_re = !empty;
            ram_raddr = slot(front, cnt - CNT_W'(1));
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        ram_re = more1;
        ram_raddr = slot(front, idx1[CNT_W-1:0]);
      end
      S_SHIFT: begin
        // Entry idx+1 has arrived: move it down one place and fetch the next.
        ram_we = 1'b1;
        ram_waddr = slot(front, idx);
        ram_wdata = ram_rdata;
        ram_re = more2;
        ram_raddr = slot(front, idx2[CNT_W-1:0]);
      end
      S_RD_HEAD: ram_re = 1'b1;
      S_RD_TAIL: begin
        ram_re = 1'b1;
        ram_raddr = slot(front, cnt - CNT_W'(1));
      end
      S_FIN: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      cnt <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_DECODE: begin
          case (op)
            OP_APPEND: begin
              if (!full) cnt <= cnt + CNT_W'(1);
            end
            OP_PUSH_HEAD: begin
              if (!full) begin
                front <= front_dec;
                cnt <= cnt + CNT_W'(1);
              end
            end
            OP_REM_HEAD: begin
              if (!empty) begin
                front <= front_inc;
                cnt <= cnt - CNT_W'(1);
              end
            end
            OP_REM_TAIL: begin
              if (!empty) cnt <= cnt - CNT_W'(1);
            end
            default: ;
          endcase
        end
        S_SEARCH: begin
          if (match && !more1) cnt <= cnt - CNT_W'(1);
        end
        S_SHIFT: begin
          if (!more2) cnt <= cnt - CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op <= op_t'(opcode);
        val <= value;
      end
      S_DECODE: begin
        removed <= '0;
        idx <= '0;
        stat <= ST_OK;
        case (op) inside
          OP_APPEND, OP_PUSH_HEAD: begin
            if (full) stat <= ST_FULL;
          end
          OP_REM_MATCH, OP_REM_HEAD, OP_REM_TAIL: begin
            if (empty) stat <= ST_EMPTY;
          end
          default: ;
        endcase
      end
      S_TAKE: removed <= ram_rdata;
      S_SEARCH: begin
        if (match) begin
          removed <= ram_rdata;
        end else begin
          idx <= idx1[CNT_W-1:0];
          if (!more1) stat <= ST_NOTFOUND;
        end
      end
      S_SHIFT: begin
        if (more2) idx <= idx1[CNT_W-1:0];
      end
      S_RD_TAIL: head <= ram_rdata;
      default: ;
    endcase
  end

  // The tail word stays in the RAM read register while the result waits.
  always_comb begin
    res.status = stat;
    res.removed_value = removed;
    res.count = cnt;
    if (empty) begin
      res.head_value = '0;
      res.tail_value = '0;
    end else begin
      res.head_value = head;
      res.tail_value = ram_rdata;
    end
  end

endmodule

// ----- hdl/ble_out_reg.sv -----
// Output register that holds one result until the receiver takes it.
module ble_out_reg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              res_valid,
  output logic                              res_ready,
  input  ble_pkg::result_t                  res,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ble_pkg::STAT_W-1:0]        status,
  output logic signed [ble_pkg::DATA_W-1:0] removed_value,
  output logic signed [ble_pkg::DATA_W-1:0] head_value,
  output logic signed [ble_pkg::DATA_W-1:0] tail_value,
  output logic [ble_pkg::CNT_W-1:0]         count
);
  import ble_pkg::*;

  result_t held;

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  assign status = held.status;
  assign removed_value = held.removed_value;
  assign head_value = held.head_value;
  assign tail_value = held.tail_value;
  assign count = held.count;

endmodule

// ----- hdl/bounded_list_engine.sv -----
// Top level of the bounded list engine: capacity register, sequencer, output register.
//
// The block keeps an ordered list of signed 32-bit values in a ring held in
// one RAM. A request on the in channel (opcode, value) appends at the tail,
// inserts at the head, removes the first match, removes the head or removes
// the tail. Every request gives exactly one result on the out channel:
// status, removed value, head and tail after the operation, and count.
// The cfg channel writes the capacity; write it only while no request is
// in flight. cfg_ready is always high.
// Append, insert and unused opcodes pass from decode through the head and
// tail reads to the result; head or tail removal adds a state that takes the
// removed entry, and remove match adds one RAM read per entry searched and one
// read and write per entry moved to close the gap. A new request is taken in
// the cycle after the previous result leaves the sequencer.
// The sequencer handles one request at a time through the RAM's single
// read port and single write port.
// Reset empties the list and sets the capacity to sixteen; RAM contents are
// not cleared. When the receiver stalls, one result waits in the output
// register while the next request is processed, which then holds until the
// output register frees up.
module bounded_list_engine #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ble_pkg::CNT_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ble_pkg::OP_W-1:0]          opcode,
  input  logic signed [ble_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ble_pkg::STAT_W-1:0]        status,
  output logic signed [ble_pkg::DATA_W-1:0] removed_value,
  output logic signed [ble_pkg::DATA_W-1:0] head_value,
  output logic signed [ble_pkg::DATA_W-1:0] tail_value,
  output logic [ble_pkg::CNT_W-1:0]         count
);
  import ble_pkg::*;

`include "bounded_list_engine_assert.svh"

  localparam int LIM_CAP = (MAX_ENTRIES > 31) ? 31 : MAX_ENTRIES;

  logic [CNT_W-1:0] capacity;
  logic             res_valid, res_ready;
  result_t          res;
  logic [CNT_W-1:0] cap_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  ble_seq #(.MAX_ENTRIES(MAX_ENTRIES)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .value     (value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ble_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .removed_value (removed_value),
    .head_value    (head_value),
    .tail_value    (tail_value),
    .count         (count)
  );

  assign cap_limit = (capacity > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : capacity;

  `BLE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `BLE_ASSERT_NOW(a_empty_status_count, res_valid && res.status == ST_EMPTY,
                  res.count == '0)
  `BLE_ASSERT_NOW(a_full_status_count, res_valid && res.status == ST_FULL,
                  res.count >= cap_limit)
  `BLE_ASSERT_NOW(a_count_bound, res_valid,
                  (CNT_W+11)'(res.count) <= (CNT_W+11)'(MAX_ENTRIES))

endmodule
